>>> hdl/tc_pkg.sv
// Package for the trace cache: sizes, codes and state type.
`timescale 1ns / 1ps
package tc_pkg;
    localparam int NUM_SETS_DEF = 64;
    localparam int NUM_WAYS_DEF = 4;
    localparam int MAX_UOPS_DEF = 16;
    localparam int MAX_RESULTS = 16;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic CFG_UOP_LIMIT = 1'b0;
    localparam logic CFG_BR_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_APPEND,
        ST_FL_RD,
        ST_FL_CMP,
        ST_FL_AGE,
        ST_FL_WR,
        ST_FL_COPY,
        ST_ADD,
        ST_LK_RD,
        ST_LK_CMP,
        ST_LK_ADDR,
        ST_LK_OUT
    } state_t;
endpackage

>>> hdl/trace_cache_fill_and_lookup.sv
// Top level of the trace cache: build trace, line store and lookup sequencer.
`timescale 1ns / 1ps
// An append that closes a trace takes longer than one that only adds, since one compare
// unit visits the ways one after another and the instruction addresses are copied one
// per cycle into the address memory.
// A lookup compares the ways one after another; on a hit each address of the line is read
// in a state of its own before it is shown, and a miss shows a single zero result.
// After reset a clearing pass visits every line, clears its metadata and sets its age to its way number.
module trace_cache_fill_and_lookup #(
    parameter int NUM_SETS = tc_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = tc_pkg::NUM_WAYS_DEF,
    parameter int MAX_TRACE_UOPS = tc_pkg::MAX_UOPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: is_head[0], inst_addr[32:1], inst_uops[37:33], inst_bytes[41:38],
    // is_control[42], actual_next[74:43], branch_target[106:75], pred_bits[123:107]
    input  logic [127:0] s_tdata,
    // tuser: action
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: trace_inst_addr[31:0], trace_insts[36:32], next_fetch[68:37]
    output logic [71:0]  m_tdata,
    // tuser: hit
    output logic         m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [4:0]   cfg_data
);
    import tc_pkg::*;

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int LINES = NUM_SETS * NUM_WAYS;
    localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int POS_W = (MAX_TRACE_UOPS > 1) ? $clog2(MAX_TRACE_UOPS) : 1;
    localparam int AMEM_W = LINE_W + POS_W;
    localparam int AGE_W = WAY_W;
    localparam logic [5:0] MAX_U = 6'(MAX_TRACE_UOPS);
    // Line metadata word: tag, mask, flags, bcount, target, fall, icount, ends.
    localparam int META_W = 32 + 16 + 16 + 5 + 32 + 32 + 6 + 1;

    typedef struct packed {
        logic [31:0] tag;
        logic [15:0] mask;
        logic [15:0] flags;
        logic [4:0]  bcnt;
        logic [31:0] target;
        logic [31:0] fall;
        logic [5:0]  icnt;
        logic        ends;
    } meta_t;

    // Input fields.
    logic        in_head, in_ctl;
    logic [31:0] in_addr, in_next, in_tgt;
    logic [4:0]  in_uops;
    logic [3:0]  in_bytes;
    logic [16:0] in_pred;
    assign in_head  = s_tdata[0];
    assign in_addr  = s_tdata[32:1];
    assign in_uops  = s_tdata[37:33];
    assign in_bytes = s_tdata[41:38];
    assign in_ctl   = s_tdata[42];
    assign in_next  = s_tdata[74:43];
    assign in_tgt   = s_tdata[106:75];
    assign in_pred  = s_tdata[123:107];

    // Memories: metadata and ages per line, addresses per line slot.
    meta_t             meta_mem [LINES];
    logic [AGE_W-1:0]  age_mem [LINES];
    logic [31:0]       amem [LINES * MAX_TRACE_UOPS];
    logic [31:0]       bmem [MAX_TRACE_UOPS];

    state_t state_reg, state_next;
    logic [4:0] uop_lim_reg, br_lim_reg;
    meta_t build_reg, build_next;
    logic [5:0] buop_reg, buop_next;
    logic [31:0] iaddr_reg, inext_reg, itgt_reg;
    logic [4:0]  iuops_reg;
    logic [3:0]  ibytes_reg;
    logic        ictl_reg, lk_reg;
    logic [16:0] pred_reg;
    logic [LINE_W-1:0] clr_reg, clr_next;
    logic [WAY_W:0] way_reg, way_next;
    logic [WAY_W-1:0] sel_reg, sel_next;
    logic found_reg, found_next, wrap_reg, wrap_next;
    logic [POS_W:0] pos_reg, pos_next;
    logic [4:0] n_reg, n_next;
    logic [31:0] nf_reg, nf_next;
    meta_t rd_meta;
    logic [AGE_W-1:0] rd_age;
    logic [31:0] rd_addr, rd_b;
    logic out_v_reg, out_v_next, out_hit_reg, out_hit_next, out_last_reg, out_last_next;
    logic [31:0] out_a_reg, out_a_next;
    logic [4:0] out_n_reg, out_n_next;

    // Control signals of the datapath.
    logic meta_we, age_we, amem_we, bmem_we, after_add_reg, after_add_next;
    logic [LINE_W-1:0] meta_wa, age_wa, rd_line;
    meta_t meta_wd;
    logic [AGE_W-1:0] age_wd;
    logic [AMEM_W-1:0] amem_ra, amem_wa;
    logic [POS_W-1:0] bmem_ra, bmem_wa;

    logic [31:0] cur_tag;
    logic [SET_W-1:0] set_idx;
    logic [LINE_W-1:0] cur_line, sel_line;
    logic [5:0] lim;
    logic [4:0] bcnt_dec;
    assign lim = (uop_lim_reg > 5'(MAX_U)) ? MAX_U : {1'b0, uop_lim_reg};
    assign cur_tag = lk_reg ? iaddr_reg : build_reg.tag;
    assign set_idx = (NUM_SETS > 1) ? SET_W'(cur_tag % NUM_SETS) : '0;
    assign cur_line = LINE_W'({set_idx, WAY_W'(way_reg)} >> ((NUM_WAYS > 1) ? 0 : 1));
    assign sel_line = LINE_W'({set_idx, sel_reg} >> ((NUM_WAYS > 1) ? 0 : 1));

    always_ff @(posedge aclk) begin
        if (meta_we) meta_mem[meta_wa] <= meta_wd;
        if (age_we) age_mem[age_wa] <= age_wd;
        if (amem_we) amem[amem_wa] <= rd_b;
        if (bmem_we) bmem[bmem_wa] <= iaddr_reg;
        rd_meta <= meta_mem[rd_line];
        rd_age  <= age_mem[rd_line];
        rd_addr <= amem[amem_ra];
        rd_b    <= bmem[bmem_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            uop_lim_reg <= 5'd16;
            br_lim_reg <= 5'd3;
            build_reg <= '0;
            buop_reg <= '0;
            clr_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            build_reg <= build_next;
            buop_reg <= buop_next;
            clr_reg <= clr_next;
            out_v_reg <= out_v_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_UOP_LIMIT) uop_lim_reg <= cfg_data;
                else br_lim_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            lk_reg <= s_tuser; iaddr_reg <= in_addr; inext_reg <= in_next;
            itgt_reg <= in_tgt; iuops_reg <= in_uops; ibytes_reg <= in_bytes;
            ictl_reg <= in_ctl; pred_reg <= in_pred;
        end
        way_reg <= way_next; sel_reg <= sel_next; found_reg <= found_next;
        wrap_reg <= wrap_next; pos_reg <= pos_next; n_reg <= n_next; nf_reg <= nf_next;
        out_hit_reg <= out_hit_next; out_last_reg <= out_last_next;
        out_a_reg <= out_a_next; out_n_reg <= out_n_next; after_add_reg <= after_add_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready = (state_reg == ST_IDLE) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata = {3'b0, nf_reg, out_n_reg, out_a_reg};
    assign m_tuser = out_hit_reg;
    assign m_tlast = out_last_reg;
    assign bcnt_dec = build_reg.bcnt - 5'd1;

    always_comb begin
        logic [31:0] fall;
        logic [4:0] bc;
        logic match;
        logic [5:0] take;
        state_next = state_reg;
        build_next = build_reg;
        buop_next = buop_reg;
        clr_next = clr_reg;
        way_next = way_reg;
        sel_next = sel_reg;
        found_next = found_reg;
        wrap_next = wrap_reg;
        pos_next = pos_reg;
        n_next = n_reg;
        nf_next = nf_reg;
        out_v_next = out_v_reg;
        out_hit_next = out_hit_reg;
        out_last_next = out_last_reg;
        out_a_next = out_a_reg;
        out_n_next = out_n_reg;
        after_add_next = after_add_reg;
        meta_we = 1'b0; meta_wa = cur_line; meta_wd = build_reg;
        age_we = 1'b0; age_wa = cur_line; age_wd = '0;
        amem_we = 1'b0; amem_wa = '0; amem_ra = '0;
        bmem_we = 1'b0; bmem_wa = build_reg.icnt[POS_W-1:0]; bmem_ra = '0;
        rd_line = cur_line;
        fall = iaddr_reg + {28'b0, ibytes_reg};
        bc = build_reg.bcnt;
        match = 1'b0;
        take = '0;
        if (out_v_reg && m_tready) out_v_next = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                meta_we = 1'b1; meta_wa = clr_reg; meta_wd = '0;
                age_we = 1'b1; age_wa = clr_reg;
                age_wd = AGE_W'(clr_reg % NUM_WAYS);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LINE_W'(LINES - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                way_next = '0; found_next = 1'b0; wrap_next = 1'b0;
                if (s_tvalid && s_tready) begin
                    if (s_tuser == ACT_LOOKUP) state_next = ST_LK_RD;
                    else if (in_head) state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                after_add_next = 1'b0;
                if ({1'b0, buop_reg} + {2'b0, iuops_reg} > {1'b0, lim}
                    || build_reg.icnt >= MAX_U) begin
                    state_next = ST_FL_RD;
                end else begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if ({1'b0, iuops_reg} > lim) begin
                    state_next = ST_IDLE;
                end else begin
                    if (build_reg.icnt == 6'd0) build_next.tag = iaddr_reg;
                    bmem_we = 1'b1;
                    build_next.icnt = build_reg.icnt + 6'd1;
                    buop_next = buop_reg + {1'b0, iuops_reg};
                    build_next.target = '0;
                    build_next.ends = 1'b0;
                    build_next.fall = fall;
                    state_next = ST_IDLE;
                    if (ictl_reg) begin
                        if (bc < 5'd16) begin
                            build_next.mask[bc[3:0]] = 1'b1;
                            if (inext_reg != fall) build_next.flags[bc[3:0]] = 1'b1;
                        end
                        if (bc < 5'd31) build_next.bcnt = bc + 5'd1;
                        build_next.target = itgt_reg;
                        build_next.ends = 1'b1;
                        if (((bc < 5'd31) ? bc + 5'd1 : bc) == br_lim_reg) begin
                            after_add_next = 1'b1;
                            state_next = ST_FL_RD;
                        end
                    end
                end
            end
            ST_FL_RD: begin
                way_next = '0; found_next = 1'b0; wrap_next = 1'b0; sel_next = '0;
                if (build_reg.icnt == 6'd0) begin
                    state_next = after_add_reg ? ST_IDLE : ST_ADD;
                end else if (build_reg.tag == 32'd0) begin
                    build_next = '0; buop_next = '0;
                    state_next = after_add_reg ? ST_IDLE : ST_ADD;
                end else begin
                    if (build_reg.ends && build_reg.bcnt != 5'd0) begin
                        build_next.bcnt = bcnt_dec;
                        if (bcnt_dec < 5'd16) begin
                            build_next.mask[bcnt_dec[3:0]] = 1'b0;
                            build_next.flags[bcnt_dec[3:0]] = 1'b0;
                        end
                    end
                    state_next = ST_FL_CMP;
                end
            end
            ST_FL_CMP: begin
                // One way a cycle: read issued here, result seen next cycle.
                if (way_reg != '0) begin
                    match = (rd_meta.tag == build_reg.tag && rd_meta.mask == build_reg.mask
                             && rd_meta.flags == build_reg.flags) || rd_meta.tag == 32'd0;
                end
                if (match) begin
                    sel_next = WAY_W'(way_reg - 1'b1);
                    found_next = 1'b1;
                    state_next = ST_FL_WR;
                end else if (way_reg == (WAY_W+1)'(NUM_WAYS)) begin
                    way_next = '0;
                    state_next = ST_FL_AGE;
                end else begin
                    way_next = way_reg + 1'b1;
                end
            end
            ST_FL_AGE: begin
                // Age update: read a way, then write it back in the next cycle.
                if (way_reg != '0) begin
                    age_we = 1'b1;
                    age_wa = LINE_W'({set_idx, WAY_W'(way_reg - 1'b1)}
                                     >> ((NUM_WAYS > 1) ? 0 : 1));
                    if (rd_age == '0) begin
                        age_wd = AGE_W'(NUM_WAYS - 1);
                        sel_next = WAY_W'(way_reg - 1'b1);
                    end else begin
                        age_wd = rd_age - 1'b1;
                    end
                end
                if (way_reg == (WAY_W+1)'(NUM_WAYS)) state_next = ST_FL_WR;
                else way_next = way_reg + 1'b1;
            end
            ST_FL_WR: begin
                meta_we = 1'b1; meta_wa = sel_line;
                pos_next = '0;
                state_next = ST_FL_COPY;
            end
            ST_FL_COPY: begin
                // Copy build addresses; each amem write follows its bmem read in the next cycle.
                bmem_ra = pos_reg[POS_W-1:0];
                if (pos_reg != '0) begin
                    amem_we = 1'b1;
                    amem_wa = {sel_line, POS_W'(pos_reg - 1'b1)};
                end
                if ({1'b0, pos_reg} == 6'(build_reg.icnt) || pos_reg == (POS_W+1)'(MAX_U)) begin
                    build_next = '0; buop_next = '0;
                    state_next = after_add_reg ? ST_IDLE : ST_ADD;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_LK_RD: begin
                way_next = '0;
                state_next = ST_LK_CMP;
            end
            ST_LK_CMP: begin
                if (way_reg != '0) begin
                    match = rd_meta.tag != 32'd0 && rd_meta.tag == iaddr_reg
                            && ((pred_reg[15:0] & rd_meta.mask) == rd_meta.flags);
                end
                if (match) begin
                    sel_next = WAY_W'(way_reg - 1'b1);
                    nf_next = rd_meta.fall;
                    if (rd_meta.ends && rd_meta.bcnt < 5'd17 && pred_reg[rd_meta.bcnt])
                        nf_next = rd_meta.target;
                    take = (rd_meta.icnt > 6'(MAX_RESULTS)) ? 6'(MAX_RESULTS) : rd_meta.icnt;
                    if (take > MAX_U) take = MAX_U;
                    n_next = 5'(rd_meta.icnt);
                    pos_next = '0;
                    out_n_next = (take == 6'd0) ? 5'd1 : 5'(take);
                    state_next = ST_LK_ADDR;
                end else if (way_reg == (WAY_W+1)'(NUM_WAYS)) begin
                    out_v_next = 1'b1; out_hit_next = 1'b0; out_last_next = 1'b1;
                    out_a_next = '0; n_next = '0; nf_next = '0; out_n_next = '0;
                    state_next = ST_LK_OUT;
                end else begin
                    way_next = way_reg + 1'b1;
                end
            end
            ST_LK_ADDR: begin
                amem_ra = {sel_line, pos_reg[POS_W-1:0]};
                if (!out_v_reg || m_tready) state_next = ST_LK_OUT;
            end
            ST_LK_OUT: begin
                if (!out_v_reg) begin
                    if (!out_hit_reg && out_last_reg && n_reg == 5'd0 && pos_reg == '0
                        && out_n_reg == 5'd0) begin
                        state_next = ST_IDLE;
                    end else begin
                        out_v_next = 1'b1; out_hit_next = 1'b1;
                        out_a_next = ({1'b0, pos_reg} < 6'(n_reg)) ? rd_addr : 32'd0;
                        out_last_next = (5'(pos_reg) + 5'd1 == out_n_reg);
                        state_next = ST_LK_ADDR;
                        if (5'(pos_reg) + 5'd1 == out_n_reg) state_next = ST_IDLE;
                        pos_next = pos_reg + 1'b1;
                    end
                end else if (m_tready && out_last_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // Hit count shown: line instruction count, capped by MAX_RESULTS and MAX_U, at least one.
        if (state_reg == ST_LK_OUT && !out_v_reg && out_hit_next) out_n_next = out_n_reg;
    end
endmodule

>>> hdl/tc_checker.sv
// Port checker for the trace cache, bound to the top level.
`timescale 1ns / 1ps
module tc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    a_miss_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast) else $error("miss without last");
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 72'd0)) else $error("miss data not zero");
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken during output");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))) else $error("dropped");
endmodule

bind trace_cache_fill_and_lookup tc_checker u_tc_checker (.*);
